>>> sv/psched_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task scheduler package
// Shared widths, codes, beat types and the controller/datapath link types.
// ----------------------------------------------------------------------------
package psched_pkg;

    // Default sizing of the slot table
    localparam int SLOT_COUNT_DEF = 16;
    localparam int TIME_BITS_DEF  = 8;

    // Fixed field widths of the channels
    localparam int SLOT_W     = 4;
    localparam int BURST_W    = 8;
    localparam int PRIO_W     = 8;
    localparam int EVENT_W    = 3;
    localparam int TLEFT_W    = 8;
    localparam int DONE_CNT_W = 8;
    localparam int DISP_CNT_W = 16;
    localparam int BUSY_CNT_W = 16;
    localparam int QUSED_W    = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 1'd1;
    localparam logic [1:0]           POLICY_RST  = 2'd0;
    localparam logic [7:0]           QUANTUM_RST = 8'd4;

    // Scheduling policies (code 3 falls through to first come first served)
    localparam logic [1:0] POL_FCFS = 2'd0;
    localparam logic [1:0] POL_RR   = 2'd1;
    localparam logic [1:0] POL_PRIO = 2'd2;

    // Opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Slot status codes
    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_READY = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // Result event codes
    localparam logic [EVENT_W-1:0] EV_LOADED   = 3'd0;
    localparam logic [EVENT_W-1:0] EV_RAN      = 3'd1;
    localparam logic [EVENT_W-1:0] EV_FINISHED = 3'd2;
    localparam logic [EVENT_W-1:0] EV_QUANTUM  = 3'd3;
    localparam logic [EVENT_W-1:0] EV_IDLE     = 3'd4;

    // Input beat
    typedef struct packed {
        logic                opcode;
        logic [SLOT_W-1:0]   slot;
        logic [BURST_W-1:0]  burst_time;
        logic [PRIO_W-1:0]   priority_req;
    } t_task_beat;

    // Result beat
    typedef struct packed {
        logic [EVENT_W-1:0]    event_res;
        logic [SLOT_W-1:0]     task_slot;
        logic [TLEFT_W-1:0]    time_left;
        logic [DONE_CNT_W-1:0] completed_count;
        logic [DISP_CNT_W-1:0] dispatch_count;
        logic [BUSY_CNT_W-1:0] busy_ticks;
    } t_event_beat;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic load;
        logic scan_step;
        logic pick;
        logic run;
        logic emit;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_tick;
        logic run_vld;
        logic scan_last;
        logic found;
        logic out_free;
    } t_dp_status;

endpackage

>>> sv/psched_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one beat of type T.
// ----------------------------------------------------------------------------
interface psched_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> sv/psched_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences one beat at a time: decode, load or scan/dispatch/run, emit.
// ----------------------------------------------------------------------------
module psched_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_task_valid,
    output logic                   o_task_ready,
    input  psched_pkg::t_dp_status i_status,
    output psched_pkg::t_dp_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_LOAD     = 4'd2;
    localparam logic [3:0] S_SCAN     = 4'd3;
    localparam logic [3:0] S_SCAN_END = 4'd4;
    localparam logic [3:0] S_PICK     = 4'd5;
    localparam logic [3:0] S_READ     = 4'd6;
    localparam logic [3:0] S_RUN      = 4'd7;
    localparam logic [3:0] S_OUT      = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_task_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_task_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_status.is_tick) begin
                    n_state = S_LOAD;
                end else if (i_status.run_vld) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_OUT;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                n_state = S_PICK;
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                n_state    = i_status.found ? S_READ : S_OUT;
            end
            S_READ: begin
                n_state = S_RUN;
            end
            S_RUN: begin
                o_cmd.run = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> sv/psched_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler datapath
// Slot table, time and priority memories, selection scan, run update,
// counters, configuration registers and the output register.
// ----------------------------------------------------------------------------
module psched_dp #(
    parameter int SLOT_COUNT = psched_pkg::SLOT_COUNT_DEF,
    parameter int TIME_BITS  = psched_pkg::TIME_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [psched_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [psched_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  psched_pkg::t_task_beat              i_task,
    input  psched_pkg::t_dp_cmd                 i_cmd,
    output psched_pkg::t_dp_status              o_status,
    output psched_pkg::t_event_beat             o_event,
    output logic                                o_event_valid,
    input  logic                                i_event_ready
);

    localparam int SLOT_BITS = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int SUM_W     = SLOT_BITS + 1;
    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(SLOT_COUNT - 1);
    localparam logic [SUM_W-1:0]     SLOT_NUM  = SUM_W'(SLOT_COUNT);

    // Configuration
    logic [1:0] r_policy;
    logic [7:0] r_quantum;

    // Latched input beat
    psched_pkg::t_task_beat r_item;

    // Slot table and memories
    logic [1:0]                      r_status   [SLOT_COUNT];
    logic [TIME_BITS-1:0]            r_time_mem [SLOT_COUNT];
    logic [psched_pkg::PRIO_W-1:0]   r_prio_mem [SLOT_COUNT];
    logic [TIME_BITS-1:0]            r_time_rd;
    logic [psched_pkg::PRIO_W-1:0]   r_prio_rd;

    // Scheduler state
    logic [SLOT_BITS-1:0]              r_run_slot;
    logic                              r_run_vld;
    logic [psched_pkg::QUSED_W-1:0]    r_qused;
    logic [SLOT_BITS-1:0]              r_ptr;
    logic [psched_pkg::DONE_CNT_W-1:0] r_finished;
    logic [psched_pkg::DISP_CNT_W-1:0] r_dispatch;
    logic [psched_pkg::BUSY_CNT_W-1:0] r_busy;

    // Scan pipeline
    logic [SLOT_BITS-1:0]            r_scan_cnt;
    logic                            r_p_vld;
    logic [SLOT_BITS-1:0]            r_p_idx;
    logic                            r_p_ready;
    logic                            r_best_vld;
    logic [SLOT_BITS-1:0]            r_best_idx;
    logic [psched_pkg::PRIO_W-1:0]   r_best_prio;

    // Pending result and output register
    logic [psched_pkg::EVENT_W-1:0]  r_res_event;
    logic [psched_pkg::SLOT_W-1:0]   r_res_slot;
    logic [psched_pkg::TLEFT_W-1:0]  r_res_tl;
    psched_pkg::t_event_beat         r_out;
    logic                            r_out_vld;

    // Load decode
    logic [SLOT_BITS-1:0] ld_idx;
    logic                 ld_in_range;
    logic [TIME_BITS-1:0] ld_burst;
    logic                 ld_hits_run;

    assign ld_idx      = SLOT_BITS'(r_item.slot);
    assign ld_in_range = int'(r_item.slot) < SLOT_COUNT;
    assign ld_burst    = TIME_BITS'(r_item.burst_time);
    assign ld_hits_run = r_run_vld && (r_run_slot == ld_idx);

    // Scan address: cyclic from the pointer for round robin, linear otherwise
    logic [SUM_W-1:0]     scan_sum;
    logic [SUM_W-1:0]     scan_wrap;
    logic [SLOT_BITS-1:0] scan_idx;

    assign scan_sum  = {1'b0, r_ptr} + {1'b0, r_scan_cnt};
    assign scan_wrap = (scan_sum >= SLOT_NUM) ? (scan_sum - SLOT_NUM) : scan_sum;
    assign scan_idx  = (r_policy == psched_pkg::POL_RR) ? scan_wrap[SLOT_BITS-1:0]
                                                        : r_scan_cnt;

    // Candidate takeover: first ready slot, or strictly higher priority
    logic take;
    assign take = r_p_vld && r_p_ready &&
                  (!r_best_vld ||
                   ((r_policy == psched_pkg::POL_PRIO) && (r_prio_rd > r_best_prio)));

    // Run update for one tick
    logic [TIME_BITS-1:0]           tl_dec;
    logic [psched_pkg::QUSED_W-1:0] qused_inc;
    logic [7:0]                     q_lim;
    logic                           run_done;
    logic                           q_end;

    assign tl_dec    = (r_time_rd != '0) ? (r_time_rd - 1'b1) : r_time_rd;
    assign qused_inc = (r_qused != '1) ? (r_qused + 1'b1) : r_qused;
    assign q_lim     = (r_quantum == '0) ? 8'd1 : r_quantum;
    assign run_done  = (tl_dec == '0);
    assign q_end     = (r_policy == psched_pkg::POL_RR) && (qused_inc >= q_lim);

    // Status to controller
    assign o_status.is_tick   = (r_item.opcode == psched_pkg::OP_TICK);
    assign o_status.run_vld   = r_run_vld;
    assign o_status.scan_last = (r_scan_cnt == LAST_SLOT);
    assign o_status.found     = r_best_vld;
    assign o_status.out_free  = !r_out_vld || i_event_ready;

    assign o_event       = r_out;
    assign o_event_valid = r_out_vld;

    // Hold the input beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_task;
        end
    end

    // Memories: write on load or run, registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && ld_in_range) begin
            r_time_mem[ld_idx] <= ld_burst;
            r_prio_mem[ld_idx] <= r_item.priority_req;
        end else if (i_cmd.run) begin
            r_time_mem[r_run_slot] <= tl_dec;
        end
        r_time_rd <= r_time_mem[r_run_slot];
        r_prio_rd <= r_prio_mem[scan_idx];
    end

    // Scan pipeline payload
    always_ff @(posedge i_clk) begin
        r_p_idx   <= scan_idx;
        r_p_ready <= (r_status[scan_idx] == psched_pkg::ST_READY);
        if (take) begin
            r_best_idx  <= r_p_idx;
            r_best_prio <= r_prio_rd;
        end
    end

    // Slot status table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_status[i] <= psched_pkg::ST_EMPTY;
            end
        end else if (i_cmd.load && ld_in_range) begin
            r_status[ld_idx] <= (ld_burst == '0) ? psched_pkg::ST_DONE
                                                 : psched_pkg::ST_READY;
        end else if (i_cmd.pick && r_best_vld) begin
            r_status[r_best_idx] <= psched_pkg::ST_RUN;
        end else if (i_cmd.run) begin
            if (run_done) begin
                r_status[r_run_slot] <= psched_pkg::ST_DONE;
            end else if (q_end) begin
                r_status[r_run_slot] <= psched_pkg::ST_READY;
            end
        end
    end

    // Scheduler control state, counters and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy   <= psched_pkg::POLICY_RST;
            r_quantum  <= psched_pkg::QUANTUM_RST;
            r_run_slot <= '0;
            r_run_vld  <= 1'b0;
            r_qused    <= '0;
            r_ptr      <= '0;
            r_finished <= '0;
            r_dispatch <= '0;
            r_busy     <= '0;
            r_scan_cnt <= '0;
            r_p_vld    <= 1'b0;
            r_best_vld <= 1'b0;
        end else begin
            // Configuration writes
            if (i_cfg_we) begin
                if (i_cfg_idx == psched_pkg::CFG_POLICY) begin
                    r_policy <= i_cfg_data[1:0];
                end else if (i_cfg_idx == psched_pkg::CFG_QUANTUM) begin
                    r_quantum <= i_cfg_data;
                end
            end

            // Scan sequencing
            r_p_vld <= i_cmd.scan_step;
            if (i_cmd.accept) begin
                r_scan_cnt <= '0;
                r_best_vld <= 1'b0;
            end else begin
                if (i_cmd.scan_step) begin
                    r_scan_cnt <= r_scan_cnt + 1'b1;
                end
                if (take) begin
                    r_best_vld <= 1'b1;
                end
            end

            // Reload of the running slot ends its turn
            if (i_cmd.load && ld_in_range && ld_hits_run) begin
                r_run_vld <= 1'b0;
                r_qused   <= '0;
            end

            // Dispatch the chosen slot
            if (i_cmd.pick && r_best_vld) begin
                r_run_slot <= r_best_idx;
                r_run_vld  <= 1'b1;
                r_qused    <= '0;
                r_ptr      <= (r_best_idx == LAST_SLOT) ? '0 : (r_best_idx + 1'b1);
                if (r_dispatch != '1) begin
                    r_dispatch <= r_dispatch + 1'b1;
                end
            end

            // Run one tick
            if (i_cmd.run) begin
                if (r_busy != '1) begin
                    r_busy <= r_busy + 1'b1;
                end
                if (run_done) begin
                    r_run_vld <= 1'b0;
                    r_qused   <= '0;
                    if (r_finished != '1) begin
                        r_finished <= r_finished + 1'b1;
                    end
                end else if (q_end) begin
                    r_run_vld <= 1'b0;
                    r_qused   <= '0;
                end else begin
                    r_qused <= qused_inc;
                end
            end
        end
    end

    // Pending result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_res_event <= psched_pkg::EV_LOADED;
            r_res_slot  <= r_item.slot;
            r_res_tl    <= ld_in_range ? psched_pkg::TLEFT_W'(ld_burst) : '0;
        end else if (i_cmd.pick && !r_best_vld) begin
            r_res_event <= psched_pkg::EV_IDLE;
            r_res_slot  <= '0;
            r_res_tl    <= '0;
        end else if (i_cmd.run) begin
            r_res_slot <= psched_pkg::SLOT_W'(r_run_slot);
            if (run_done) begin
                r_res_event <= psched_pkg::EV_FINISHED;
                r_res_tl    <= '0;
            end else begin
                r_res_event <= q_end ? psched_pkg::EV_QUANTUM : psched_pkg::EV_RAN;
                r_res_tl    <= psched_pkg::TLEFT_W'(tl_dec);
            end
        end
    end

    // Output register: load on emit, drop when the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (i_event_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.event_res       <= r_res_event;
            r_out.task_slot       <= r_res_slot;
            r_out.time_left       <= r_res_tl;
            r_out.completed_count <= r_finished;
            r_out.dispatch_count  <= r_dispatch;
            r_out.busy_ticks      <= r_busy;
        end
    end

endmodule

>>> sv/process_scheduler_fcfs_rr_priority.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task scheduler (first come first served, round robin, priority)
// Keeps a table of task slots and answers each load or tick beat with one
// event beat.
//
// i_task carries load beats (slot, burst, priority) and tick beats; o_event
// returns one beat per input beat, in order, with the event code, the slot
// touched, its remaining time and the saturating counters. Policy and
// quantum are written through i_cfg_we / i_cfg_idx / i_cfg_data; the
// user must write them only while idle, as the block does not enforce it.
// One beat is worked on at a time; i_task.ready is high only between beats.
// A load goes from decode to the load state and then to output; a tick
// with a task already running reads and runs it; a tick that must select
// a task first scans every slot, then dispatches the chosen one if any is
// ready, else it reports idle. The selection scan visits one slot per cycle.
// Reset empties every slot, clears the counters and restores the policy to
// first come first served with a quantum of 4. If the receiver stalls, the
// result waits in the output register while the next beat is taken and
// worked; that beat holds before its emit until the register frees.
// ----------------------------------------------------------------------------
module process_scheduler_fcfs_rr_priority #(
    parameter int SLOT_COUNT = psched_pkg::SLOT_COUNT_DEF,
    parameter int TIME_BITS  = psched_pkg::TIME_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [psched_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [psched_pkg::CFG_DATA_W-1:0] i_cfg_data,
    psched_stream_if.sink                     i_task,
    psched_stream_if.source                   o_event
);

    psched_pkg::t_dp_cmd     cmd;
    psched_pkg::t_dp_status  status;
    psched_pkg::t_task_beat  task_beat;
    psched_pkg::t_event_beat event_beat;
    logic                    task_ready;
    logic                    event_valid;

    assign task_beat     = i_task.data;
    assign i_task.ready  = task_ready;
    assign o_event.valid = event_valid;
    assign o_event.data  = event_beat;

    psched_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_task_valid (i_task.valid),
        .o_task_ready (task_ready),
        .i_status     (status),
        .o_cmd        (cmd)
    );

    psched_dp #(
        .SLOT_COUNT (SLOT_COUNT),
        .TIME_BITS  (TIME_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_task        (task_beat),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_event       (event_beat),
        .o_event_valid (event_valid),
        .i_event_ready (o_event.ready)
    );

endmodule
